@@ design/affine_matrix_inverse_assert.svh @@
// ----------------------------------------------------------------------------
// affine matrix inverse assertion macros
// concurrent checks on clk, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_ASSERT_SVH
`define AFFINE_MATRIX_INVERSE_ASSERT_SVH

`ifndef SYNTHESIS
`define AMI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AMI_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMI_ASSERT(name, prop, msg)
`define AMI_ASSERT_RST(name, prop, msg)
`endif

`endif

@@ design/ami_pkg.sv @@
// ----------------------------------------------------------------------------
// ami_pkg
// shared types, widths and helpers of the affine matrix inverse
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ami_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;
  localparam int COF_W     = 65;
  localparam int DET_W     = 99;
  localparam int SUM_W     = 72;
  localparam int THR_W     = 31;
  localparam int DIV_STEPS = 32;
  localparam int NUM_ENT   = 9;
  localparam int NUM_ROWS  = 3;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    ROW_0,
    ROW_1,
    ROW_2
  } row_t;

  function automatic word_t sat32(input sum_t v);
    word_t res;
    if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
      res = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = WORD_MIN;
    end else begin
      res = WORD_MAX;
    end
    return res;
  endfunction

endpackage

@@ design/affine_matrix_inverse.sv @@
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// inverts a 3x3 plus translation transform in signed fixed point
// ----------------------------------------------------------------------------
// channel  dir  handshake             word
// in       in   in_valid/in_ready     m00..m22, tx, ty, tz
// out      out  out_valid/out_ready   row, col0..col2, trans, singular, last
// cfg      in   cfg_wr_en             cfg_wr_data (singular threshold)
//
// the single result port sends three row words per item, or one word for a
//   singular item; no new item enters while an item is being sent
// the whole pipeline advances together; it holds until the output stage's last word is taken
// reset: synchronous active low, clears valid bits and sets threshold to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "affine_matrix_inverse_assert.svh"

module affine_matrix_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_m00,
  input  logic signed [31:0]   in_m01,
  input  logic signed [31:0]   in_m02,
  input  logic signed [31:0]   in_m10,
  input  logic signed [31:0]   in_m11,
  input  logic signed [31:0]   in_m12,
  input  logic signed [31:0]   in_m20,
  input  logic signed [31:0]   in_m21,
  input  logic signed [31:0]   in_m22,
  input  logic signed [31:0]   in_tx,
  input  logic signed [31:0]   in_ty,
  input  logic signed [31:0]   in_tz,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_row,
  output logic signed [31:0]   out_col0,
  output logic signed [31:0]   out_col1,
  output logic signed [31:0]   out_col2,
  output logic signed [31:0]   out_trans,
  output logic                 out_singular,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [30:0]          cfg_wr_data
);

  localparam int FB2 = 2 * FRAC_BITS;
  localparam int NW  = (FB2 + 67 > 131) ? FB2 + 67 : 131;
  localparam int NE  = ami_pkg::NUM_ENT;
  localparam int NS  = ami_pkg::DIV_STEPS;

  logic adv;
  logic [ami_pkg::THR_W-1:0] thr_r;

  ami_pkg::word_t a [0:2][0:2];
  ami_pkg::word_t t_in [0:2];

  assign a[0][0] = in_m00;
  assign a[0][1] = in_m01;
  assign a[0][2] = in_m02;
  assign a[1][0] = in_m10;
  assign a[1][1] = in_m11;
  assign a[1][2] = in_m12;
  assign a[2][0] = in_m20;
  assign a[2][1] = in_m21;
  assign a[2][2] = in_m22;
  assign t_in[0] = in_tx;
  assign t_in[1] = in_ty;
  assign t_in[2] = in_tz;

  // valid bits of the front stages
  logic [7:1] v_r;

  // stage 1: cofactor products
  ami_pkg::prod_t pa_nxt [0:NE-1];
  ami_pkg::prod_t pb_nxt [0:NE-1];
  ami_pkg::prod_t pa_r   [0:NE-1];
  ami_pkg::prod_t pb_r   [0:NE-1];
  ami_pkg::word_t a0_1_r [0:2];
  ami_pkg::word_t t1_r   [0:2];

  always_comb begin
    pa_nxt[0] = a[1][1] * a[2][2];  pb_nxt[0] = a[1][2] * a[2][1];
    pa_nxt[1] = a[0][2] * a[2][1];  pb_nxt[1] = a[0][1] * a[2][2];
    pa_nxt[2] = a[0][1] * a[1][2];  pb_nxt[2] = a[0][2] * a[1][1];
    pa_nxt[3] = a[1][2] * a[2][0];  pb_nxt[3] = a[1][0] * a[2][2];
    pa_nxt[4] = a[0][0] * a[2][2];  pb_nxt[4] = a[0][2] * a[2][0];
    pa_nxt[5] = a[0][2] * a[1][0];  pb_nxt[5] = a[0][0] * a[1][2];
    pa_nxt[6] = a[1][0] * a[2][1];  pb_nxt[6] = a[1][1] * a[2][0];
    pa_nxt[7] = a[0][1] * a[2][0];  pb_nxt[7] = a[0][0] * a[2][1];
    pa_nxt[8] = a[0][0] * a[1][1];  pb_nxt[8] = a[0][1] * a[1][0];
  end

  // stage 2: cofactors
  ami_pkg::cof_t  cof_nxt [0:NE-1];
  ami_pkg::cof_t  cof2_r  [0:NE-1];
  ami_pkg::word_t a0_2_r  [0:2];
  ami_pkg::word_t t2_r    [0:2];

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      cof_nxt[k] = {pa_r[k][ami_pkg::PROD_W-1], pa_r[k]} -
                   {pb_r[k][ami_pkg::PROD_W-1], pb_r[k]};
    end
  end

  // stage 3: determinant partial products, cofactor split in two halves
  logic signed [64:0] dlo_nxt [0:2];
  logic signed [64:0] dhi_nxt [0:2];
  logic signed [64:0] dlo_r   [0:2];
  logic signed [64:0] dhi_r   [0:2];
  ami_pkg::cof_t      cof3_r  [0:NE-1];
  ami_pkg::word_t     t3_r    [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlo_nxt[k] = a0_2_r[k] * $signed({1'b0, cof2_r[3*k][31:0]});
      dhi_nxt[k] = a0_2_r[k] * $signed(cof2_r[3*k][64:32]);
    end
  end

  // stage 4: recombine halves
  ami_pkg::det_t  term_nxt [0:2];
  ami_pkg::det_t  term_r   [0:2];
  ami_pkg::cof_t  cof4_r   [0:NE-1];
  ami_pkg::word_t t4_r     [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_nxt[k] = ({{(ami_pkg::DET_W-65){dhi_r[k][64]}}, dhi_r[k]} <<< 32) +
                    {{(ami_pkg::DET_W-65){dlo_r[k][64]}}, dlo_r[k]};
    end
  end

  // stage 5: determinant
  ami_pkg::det_t  det_nxt;
  ami_pkg::det_t  det_r;
  ami_pkg::cof_t  cof5_r [0:NE-1];
  ami_pkg::word_t t5_r   [0:2];

  assign det_nxt = term_r[0] + term_r[1] + term_r[2];

  // stage 6: magnitudes, signs, singular test
  logic [ami_pkg::DET_W-1:0] dmag_nxt;
  logic [ami_pkg::DET_W-1:0] dmag_r;
  logic [ami_pkg::DET_W-1:0] lim;
  logic [ami_pkg::COF_W-1:0] cmag_nxt [0:NE-1];
  logic [ami_pkg::COF_W-1:0] cmag_r   [0:NE-1];
  logic [NE-1:0]             neg_nxt;
  logic [NE-1:0]             neg6_r;
  logic                      sing_nxt;
  logic                      sing6_r;
  ami_pkg::word_t            t6_r [0:2];

  always_comb begin
    dmag_nxt = det_r[ami_pkg::DET_W-1] ? -det_r : det_r;
    lim      = {{(ami_pkg::DET_W-ami_pkg::THR_W){1'b0}}, thr_r} << FB2;
    sing_nxt = (det_r == '0) || (dmag_nxt < lim);
    for (int k = 0; k < NE; k++) begin
      cmag_nxt[k] = cof5_r[k][ami_pkg::COF_W-1] ? -cof5_r[k] : cof5_r[k];
      neg_nxt[k]  = cof5_r[k][ami_pkg::COF_W-1] ^ det_r[ami_pkg::DET_W-1];
    end
  end

  // stage 7: dividends and divisor for round to nearest
  logic [NW-1:0]  n_nxt [0:NE-1];
  logic [NW-1:0]  n7_r  [0:NE-1];
  logic [NW-1:0]  d_nxt;
  logic [NW-1:0]  d7_r;
  logic [NE-1:0]  neg7_r;
  logic           sing7_r;
  ami_pkg::word_t t7_r [0:2];

  always_comb begin
    d_nxt = {{(NW-ami_pkg::DET_W){1'b0}}, dmag_r} << 1;
    for (int k = 0; k < NE; k++) begin
      n_nxt[k] = ({{(NW-ami_pkg::COF_W){1'b0}}, cmag_r[k]} << (FB2 + 1)) +
                 {{(NW-ami_pkg::DET_W){1'b0}}, dmag_r};
    end
  end

  // divider pipeline: entry 0 is the range check, then one quotient bit a stage
  logic [NW-1:0]  rem_r  [0:NS][0:NE-1];
  logic [31:0]    q_r    [0:NS][0:NE-1];
  logic [NE-1:0]  ovf_r  [0:NS];
  logic [NE-1:0]  negd_r [0:NS];
  logic [NW-1:0]  dd_r   [0:NS];
  logic           singd_r [0:NS];
  ami_pkg::word_t td_r   [0:NS][0:2];
  logic [NS:0]    dv_r;
  logic [NE-1:0]  ovf_nxt;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      ovf_nxt[k] = n7_r[k] >= (d7_r << NS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        rem_r[0][k] <= n7_r[k];
        q_r[0][k]   <= '0;
      end
      ovf_r[0]   <= ovf_nxt;
      negd_r[0]  <= neg7_r;
      dd_r[0]    <= d7_r;
      singd_r[0] <= sing7_r;
      for (int k = 0; k < 3; k++) td_r[0][k] <= t7_r[k];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int SH = NS - 1 - j;
    logic [NW-1:0] rem_nxt [0:NE-1];
    logic [31:0]   q_nxt   [0:NE-1];
    logic [NW:0]   diff    [0:NE-1];

    always_comb begin
      for (int k = 0; k < NE; k++) begin
        diff[k] = {1'b0, rem_r[j][k]} - {1'b0, dd_r[j] << SH};
        rem_nxt[k] = diff[k][NW] ? rem_r[j][k] : diff[k][NW-1:0];
        q_nxt[k] = q_r[j][k];
        q_nxt[k][SH] = !diff[k][NW];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < NE; k++) begin
          rem_r[j+1][k] <= rem_nxt[k];
          q_r[j+1][k]   <= q_nxt[k];
        end
        ovf_r[j+1]   <= ovf_r[j];
        negd_r[j+1]  <= negd_r[j];
        dd_r[j+1]    <= dd_r[j];
        singd_r[j+1] <= singd_r[j];
        for (int k = 0; k < 3; k++) td_r[j+1][k] <= td_r[j][k];
      end
    end
  end

  // stage: signed, saturated inverse entries
  ami_pkg::word_t inv_nxt [0:NE-1];
  ami_pkg::word_t inv_r   [0:NE-1];
  ami_pkg::word_t ti_r    [0:2];
  logic           singi_r;
  logic           vi_r;
  logic [32:0]    qx;

  always_comb begin
    qx = '0;
    for (int k = 0; k < NE; k++) begin
      qx = {1'b0, q_r[NS][k]};
      if (ovf_r[NS][k]) begin
        inv_nxt[k] = negd_r[NS][k] ? ami_pkg::WORD_MIN : ami_pkg::WORD_MAX;
      end else if (!negd_r[NS][k]) begin
        inv_nxt[k] = q_r[NS][k][31] ? ami_pkg::WORD_MAX : q_r[NS][k];
      end else if (qx > 33'h0_8000_0000) begin
        inv_nxt[k] = ami_pkg::WORD_MIN;
      end else begin
        inv_nxt[k] = -q_r[NS][k];
      end
    end
  end

  // stage: translation products
  ami_pkg::prod_t tp_nxt [0:NE-1];
  ami_pkg::prod_t tp_r   [0:NE-1];
  ami_pkg::word_t invp_r [0:NE-1];
  logic           singp_r;
  logic           vp_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        tp_nxt[3*r+k] = inv_r[3*r+k] * ti_r[k];
      end
    end
  end

  // stage: rounded negated sums
  localparam ami_pkg::sum_t HALF = ami_pkg::sum_t'(1) <<< (FRAC_BITS - 1);
  ami_pkg::sum_t  s_nxt [0:2];
  ami_pkg::sum_t  s_r   [0:2];
  ami_pkg::word_t invs_r [0:NE-1];
  logic           sings_r;
  logic           vs_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s_nxt[r] = HALF -
        ({{(ami_pkg::SUM_W-ami_pkg::PROD_W){tp_r[3*r][ami_pkg::PROD_W-1]}}, tp_r[3*r]} +
         {{(ami_pkg::SUM_W-ami_pkg::PROD_W){tp_r[3*r+1][ami_pkg::PROD_W-1]}}, tp_r[3*r+1]} +
         {{(ami_pkg::SUM_W-ami_pkg::PROD_W){tp_r[3*r+2][ami_pkg::PROD_W-1]}}, tp_r[3*r+2]});
    end
  end

  // output stage: holds one item and sends it row by row, or as one word if singular
  logic           ser_valid_r;
  logic           ser_sing_r;
  ami_pkg::row_t  ser_row_r;
  ami_pkg::row_t  ser_row_nxt;
  ami_pkg::word_t ser_inv_r [0:NE-1];
  ami_pkg::word_t ser_tr_r  [0:2];
  logic           ser_free;

  assign ser_free = !ser_valid_r || (out_ready && out_last);
  assign adv      = ser_free;
  assign in_ready = adv;

  always_comb begin
    case (ser_row_r)
      ami_pkg::ROW_0: ser_row_nxt = ami_pkg::ROW_1;
      ami_pkg::ROW_1: ser_row_nxt = ami_pkg::ROW_2;
      default:        ser_row_nxt = ami_pkg::ROW_0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= ami_pkg::THR_W'(1);
      v_r         <= '0;
      dv_r        <= '0;
      vi_r        <= 1'b0;
      vp_r        <= 1'b0;
      vs_r        <= 1'b0;
      ser_valid_r <= 1'b0;
      ser_row_r   <= ami_pkg::ROW_0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (adv) begin
        v_r         <= {v_r[6:1], in_valid};
        dv_r        <= {dv_r[NS-1:0], v_r[7]};
        vi_r        <= dv_r[NS];
        vp_r        <= vi_r;
        vs_r        <= vp_r;
        ser_valid_r <= vs_r;
        ser_row_r   <= ami_pkg::ROW_0;
      end else if (out_valid && out_ready) begin
        ser_row_r <= ser_row_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        pa_r[k]     <= pa_nxt[k];
        pb_r[k]     <= pb_nxt[k];
        cof2_r[k]   <= cof_nxt[k];
        cof3_r[k]   <= cof2_r[k];
        cof4_r[k]   <= cof3_r[k];
        cof5_r[k]   <= cof4_r[k];
        cmag_r[k]   <= cmag_nxt[k];
        n7_r[k]     <= n_nxt[k];
        inv_r[k]    <= inv_nxt[k];
        tp_r[k]     <= tp_nxt[k];
        invp_r[k]   <= inv_r[k];
        invs_r[k]   <= invp_r[k];
        ser_inv_r[k] <= sings_r ? '0 : invs_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        a0_1_r[k]   <= a[0][k];
        a0_2_r[k]   <= a0_1_r[k];
        t1_r[k]     <= t_in[k];
        t2_r[k]     <= t1_r[k];
        t3_r[k]     <= t2_r[k];
        t4_r[k]     <= t3_r[k];
        t5_r[k]     <= t4_r[k];
        t6_r[k]     <= t5_r[k];
        t7_r[k]     <= t6_r[k];
        ti_r[k]     <= td_r[NS][k];
        dlo_r[k]    <= dlo_nxt[k];
        dhi_r[k]    <= dhi_nxt[k];
        term_r[k]   <= term_nxt[k];
        s_r[k]      <= s_nxt[k];
        ser_tr_r[k] <= sings_r ? '0 : ami_pkg::sat32(s_r[k] >>> FRAC_BITS);
      end
      det_r      <= det_nxt;
      dmag_r     <= dmag_nxt;
      neg6_r     <= neg_nxt;
      sing6_r    <= sing_nxt;
      neg7_r     <= neg6_r;
      sing7_r    <= sing6_r;
      d7_r       <= d_nxt;
      singi_r    <= singd_r[NS];
      singp_r    <= singi_r;
      sings_r    <= singp_r;
      ser_sing_r <= sings_r;
    end
  end

  always_comb begin
    out_valid    = ser_valid_r;
    out_row      = ser_row_r;
    out_singular = ser_sing_r;
    out_last     = ser_sing_r || (ser_row_r == ami_pkg::ROW_2);
    case (ser_row_r)
      ami_pkg::ROW_0: begin
        out_col0 = ser_inv_r[0]; out_col1 = ser_inv_r[1]; out_col2 = ser_inv_r[2];
        out_trans = ser_tr_r[0];
      end
      ami_pkg::ROW_1: begin
        out_col0 = ser_inv_r[3]; out_col1 = ser_inv_r[4]; out_col2 = ser_inv_r[5];
        out_trans = ser_tr_r[1];
      end
      ami_pkg::ROW_2: begin
        out_col0 = ser_inv_r[6]; out_col1 = ser_inv_r[7]; out_col2 = ser_inv_r[8];
        out_trans = ser_tr_r[2];
      end
      default: begin
        out_col0 = '0; out_col1 = '0; out_col2 = '0;
        out_trans = '0;
      end
    endcase
  end

  `AMI_ASSERT(a_last_row, out_valid && out_last |-> (out_singular || out_row == ami_pkg::ROW_2), "last word not on final row")
  `AMI_ASSERT(a_sing_zero, out_valid && out_singular |-> (out_row == ami_pkg::ROW_0 && out_col0 == 0 && out_col1 == 0 && out_col2 == 0 && out_trans == 0), "singular word carries data")
  `AMI_ASSERT(a_row_step, out_valid && out_ready && !out_last |=> out_valid && out_row == $past(out_row) + 2'd1, "row sequence broken")
  `AMI_ASSERT(a_stall_cause, !in_ready |-> out_valid && !(out_ready && out_last), "input stalled without output backpressure")
  `AMI_ASSERT_RST(a_reset_idle, !$past(rst_n) |-> !out_valid, "output valid right after reset")

endmodule
